FILE: sv/ssiafc_pkg.sv
// Shared types, constants and CRC-6 helpers for the SSI angle frame checker.
// No dependencies.
`timescale 1ns / 1ps

package ssiafc_pkg;

  localparam int FrameWidth  = 24;
  localparam int AngleWidth  = 14;
  localparam int StatusWidth = 4;
  localparam int CrcWidth    = 6;
  localparam int CountWidth  = 4;
  localparam int HalfBits    = 9;   // data bits taken by each CRC helper call

  // Register indexes on the configuration port
  localparam logic [1:0] REG_CRC_POLY   = 2'd0;
  localparam logic [1:0] REG_CRC_ENABLE = 2'd1;
  localparam logic [1:0] REG_MAX_ATT    = 2'd2;

  // Result codes
  localparam logic [1:0] OUT_VALID       = 2'd0;
  localparam logic [1:0] OUT_RETRY       = 2'd1;
  localparam logic [1:0] OUT_FAIL_FAULT  = 2'd2;
  localparam logic [1:0] OUT_FAIL_NOGOOD = 2'd3;

  // Status bit positions
  localparam int StatTrackLoss = 3;
  localparam int StatButton    = 2;

  localparam logic [CrcWidth-1:0]   POLY_RESET   = 6'h03;
  localparam logic [CountWidth-1:0] MAX_ATT_RESET = 4'd3;
  localparam logic [CountWidth-1:0] COUNT_MAX     = 4'd15;

  typedef logic [CrcWidth-1:0] crc_t;

  // Shift nine data bits, MSB first, into a running CRC-6
  function automatic crc_t crc6_nine(input crc_t crc_in, input logic [HalfBits-1:0] bits,
                                     input crc_t poly);
    crc_t crc;
    logic fb;
    crc = crc_in;
    for (int i = HalfBits - 1; i >= 0; i--) begin
      fb  = crc[CrcWidth-1] ^ bits[i];
      crc = {crc[CrcWidth-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ poly;
      end
    end
    return crc;
  endfunction

endpackage

FILE: sv/ssi_angle_frame_checker.sv
// Top level of the SSI angle frame checker: CRC-6 check, status check and
// attempt tracking for one sample read. Depends on ssiafc_pkg.
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | into      | in_valid / in_ready  | start_read, frame_word
//  out     | out of    | out_valid/ out_ready | outcome, angle, button_pressed, crc_good,
//          |           |                      | frame_status, attempt_index
//  cfg     | into      | cfg_we (no wait)     | cfg_index, cfg_data
//
// One beat per cycle sustained while the result is not stalled; an accepted beat
// sits in the stage register and then moves to the result register. The whole
// CRC and the status checks run between the stage register and the result
// register. Reset clears the read state and loads register defaults. A stalled
// result holds; the stage keeps accepting while the result register can move.

module ssi_angle_frame_checker
  import ssiafc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   start_read,
  input  logic [FrameWidth-1:0]  frame_word,
  // output channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             outcome,
  output logic [AngleWidth-1:0]  angle,
  output logic                   button_pressed,
  output logic                   crc_good,
  output logic [StatusWidth-1:0] frame_status,
  output logic [CountWidth-1:0]  attempt_index,
  // configuration
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CrcWidth-1:0]    cfg_data
);

  // Configuration registers
  crc_t                  crc_poly;
  logic                  crc_enable;
  logic [CountWidth-1:0] max_att;

  // Read state
  logic [CountWidth-1:0] attempts_used;
  logic                  fault_seen;
  logic                  read_active;

  // Stage register
  logic                  stg_valid;
  logic                  stg_start;
  logic [FrameWidth-1:0] stg_word;

  logic                  advance;
  crc_t                  crc_head;

  // Compute signals
  crc_t                  crc_full;
  logic                  fresh;
  logic [CountWidth-1:0] att_next;
  logic [CountWidth-1:0] limit;
  logic                  fault_base;
  logic                  crc_ok;
  logic [StatusWidth-1:0] status;
  logic                  good;
  logic                  ends;
  logic [1:0]            outcome_next;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly   <= POLY_RESET;
      crc_enable <= 1'b1;
      max_att    <= MAX_ATT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRC_POLY:   crc_poly   <= cfg_data;
        REG_CRC_ENABLE: crc_enable <= cfg_data[0];
        REG_MAX_ATT:    max_att    <= cfg_data[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage moves when the result register is free or being drained
  assign advance  = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_start <= start_read;
      stg_word  <= frame_word;
    end
  end

  // First nine bits of the CRC, taken from the stage register
  assign crc_head = crc6_nine('0, stg_word[FrameWidth-1 -: HalfBits], crc_poly);

  // Finish the CRC and decide the outcome
  always_comb begin
    crc_full   = crc6_nine(crc_head, stg_word[FrameWidth-1-HalfBits -: HalfBits], crc_poly);
    fresh      = stg_start || !read_active;
    att_next   = fresh ? {{(CountWidth-1){1'b0}}, 1'b1} :
                 (attempts_used == COUNT_MAX) ? COUNT_MAX : attempts_used + 1'b1;
    fault_base = fresh ? 1'b0 : fault_seen;
    limit      = (max_att == '0) ? {{(CountWidth-1){1'b0}}, 1'b1} : max_att;
    crc_ok     = !crc_enable || (crc_full == stg_word[CrcWidth-1:0]);
    status     = stg_word[CrcWidth +: StatusWidth];
    good       = crc_ok && !status[StatTrackLoss] && (status[1:0] == 2'b00);
    ends       = good || (att_next >= limit);
    if (good) begin
      outcome_next = OUT_VALID;
    end else if (att_next < limit) begin
      outcome_next = OUT_RETRY;
    end else if (fault_base || crc_ok) begin
      outcome_next = OUT_FAIL_FAULT;
    end else begin
      outcome_next = OUT_FAIL_NOGOOD;
    end
  end

  // Advance read state
  always_ff @(posedge clk) begin
    if (rst) begin
      attempts_used <= '0;
      fault_seen    <= 1'b0;
      read_active   <= 1'b0;
    end else if (advance) begin
      attempts_used <= att_next;
      fault_seen    <= fault_base || (!good && crc_ok);
      read_active   <= !ends;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      outcome        <= outcome_next;
      angle          <= good ? stg_word[FrameWidth-1 -: AngleWidth] : '0;
      button_pressed <= good && status[StatButton];
      crc_good       <= crc_ok;
      frame_status   <= status;
      attempt_index  <= att_next;
    end
  end

  // A shown result always counts at least one attempt
  a_attempt_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (attempt_index != '0))
    else $error("result with attempt index zero");

  // Angle and button are cleared unless the frame was good
  a_clear_when_bad: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome != OUT_VALID)) |-> ((angle == '0) && !button_pressed))
    else $error("angle or button set on a bad frame");

  // A retry leaves the read open
  a_retry_keeps_read: assert property (@(posedge clk) disable iff (rst)
    (advance && (outcome_next == OUT_RETRY)) |=> read_active)
    else $error("read closed after a retry");

  // A failure without fault means the CRC failed on this frame
  a_nogood_crc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == OUT_FAIL_NOGOOD)) |-> !crc_good)
    else $error("no-valid-frame failure with a clean CRC");

endmodule
